@@ rtl/process_queue_with_removal_unit_assert.svh @@
// ----------------------------------------------------------------------------
// process queue assertion macros
// concurrent assertion helpers, removable with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef PROCESS_QUEUE_WITH_REMOVAL_UNIT_ASSERT_SVH
`define PROCESS_QUEUE_WITH_REMOVAL_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked property, disabled while reset is asserted
`define PQR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also during reset
`define PQR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PQR_ASSERT(label, clk, rst_n, prop, msg)
`define PQR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ rtl/pqr_pkg.sv @@
// ----------------------------------------------------------------------------
// pqr_pkg
// shared types and codes of the process queue
// ----------------------------------------------------------------------------
package pqr_pkg;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_POP      = 2'd1,
    OP_DEL_NAME = 2'd2,
    OP_DEL_PID  = 2'd3
  } pqr_op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } pqr_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROTATE,
    S_HOLD
  } pqr_state_e;

  typedef struct packed {
    logic [63:0] name;
    logic [7:0]  prio;
    logic [21:0] pid;
    logic [30:0] runtime;
  } pqr_rec_t;

  typedef struct packed {
    pqr_status_e status;
    pqr_rec_t    rec;
  } pqr_result_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic push;   // load the pushed record into the cell at the fill index
    logic shift;  // move every record one cell toward the head
    logic wrap;   // head record re-enters at the tail during a shift
  } pqr_cell_ctrl_t;

endpackage

@@ rtl/pqr_cmd_if.sv @@
// ----------------------------------------------------------------------------
// pqr_cmd_if
// command channel of the process queue: valid/ready plus command payload
// ----------------------------------------------------------------------------
interface pqr_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] name_key;
  logic [7:0]  prio_in;
  logic [21:0] pid_in;
  logic [30:0] runtime_in;

  modport source (
    output valid, op, name_key, prio_in, pid_in, runtime_in,
    input  ready
  );
  modport sink (
    input  valid, op, name_key, prio_in, pid_in, runtime_in,
    output ready
  );
endinterface

@@ rtl/pqr_res_if.sv @@
// ----------------------------------------------------------------------------
// pqr_res_if
// result channel of the process queue: valid/ready plus status and record
// ----------------------------------------------------------------------------
interface pqr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] name_out;
  logic [7:0]  prio_out;
  logic [21:0] pid_out;
  logic [30:0] runtime_out;

  modport source (
    output valid, status, name_out, prio_out, pid_out, runtime_out,
    input  ready
  );
  modport sink (
    input  valid, status, name_out, prio_out, pid_out, runtime_out,
    output ready
  );
endinterface

@@ rtl/process_queue_with_removal_unit.sv @@
// ----------------------------------------------------------------------------
// process_queue_with_removal_unit
// order-keeping queue of process records with pop and delete by name or pid
// ----------------------------------------------------------------------------
// usage
//   cmd_i carries one command per transaction: push, pop oldest, delete by
//   name or delete by pid. res_o returns exactly one result per command:
//   a status and, for a successful pop or delete, the removed record.
//   records live in a row of QUEUE_DEPTH cells, the oldest in cell 0.
//   push and the empty or full reports finish in the accepting cycle;
//   pop and delete first pass through the rotate state. a delete
//   rotates the whole row once through cell 0, one cell per cycle, where a
//   single comparator checks the key; the match is dropped instead of
//   re-entering at the tail, so the order of the rest is kept.
//   one command is in progress at a time; the next one is taken as soon as
//   the previous result sits in the output register, even while the
//   receiver stalls. so with a free output a command can follow every cycle
//   after a push or a report; after a pop or a delete the next command
//   waits until the rotation ends.
//   if the output register is still full when a result completes, it waits
//   in a holding register and cmd_i stays not ready.
//   reset empties the queue and clears the output valid; slot contents are
//   left as they are and never read before being written.
// ----------------------------------------------------------------------------
`include "process_queue_with_removal_unit_assert.svh"

module process_queue_with_removal_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pqr_cmd_if.sink  cmd_i,
  pqr_res_if.source res_o
);

  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);

  // control state
  pqr_pkg::pqr_state_e state_q, state_d;
  logic [OCC_W-1:0]    occ_q, occ_d;       // number of records held
  logic [OCC_W-1:0]    cnt_q, cnt_d;       // rotate steps still to go
  logic                found_q, found_d;   // match already removed
  logic                out_valid_q, out_valid_d;

  // payload registers
  pqr_pkg::pqr_op_e    op_q;
  logic [63:0]         key_name_q;
  logic [21:0]         key_pid_q;
  pqr_pkg::pqr_rec_t   capt_q, capt_d;     // removed record
  pqr_pkg::pqr_result_t hold_q;            // finished result waiting for output
  pqr_pkg::pqr_result_t out_q, out_d;

  pqr_pkg::pqr_rec_t   cell_rec [QUEUE_DEPTH];
  pqr_pkg::pqr_rec_t   head;
  pqr_pkg::pqr_rec_t   cmd_rec;
  pqr_pkg::pqr_cell_ctrl_t ctrl;
  pqr_pkg::pqr_op_e    cmd_op;
  pqr_pkg::pqr_result_t done_res;

  logic cmd_fire;
  logic out_free;
  logic key_hit;
  logic hit;
  logic done;
  logic out_load;

  assign cmd_i.ready = (state_q == pqr_pkg::S_IDLE);
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign cmd_op      = pqr_pkg::pqr_op_e'(cmd_i.op);
  assign out_free    = !out_valid_q || res_o.ready;

  assign cmd_rec.name    = cmd_i.name_key;
  assign cmd_rec.prio    = cmd_i.prio_in;
  assign cmd_rec.pid     = cmd_i.pid_in;
  assign cmd_rec.runtime = cmd_i.runtime_in;

  assign head = cell_rec[0];

  // ---- cell row ----
  // every cell takes its right neighbor on a shift; the last one has none
  // and takes the head record, which is never used there
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    pqr_pkg::pqr_rec_t nbr;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr = head;
    end else begin : g_mid
      assign nbr = cell_rec[i+1];
    end
    pqr_cell #(
      .IDX   (i),
      .OCC_W (OCC_W)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .occ_i  (occ_q),
      .next_i (nbr),
      .head_i (head),
      .push_i (cmd_rec),
      .rec_o  (cell_rec[i])
    );
  end

  // ---- key compare at the head cell ----
  always_comb begin
    unique case (op_q)
      pqr_pkg::OP_DEL_NAME: key_hit = (head.name == key_name_q);
      pqr_pkg::OP_DEL_PID:  key_hit = (head.pid == key_pid_q);
      pqr_pkg::OP_POP:      key_hit = 1'b1;
      default:              key_hit = 1'b0;
    endcase
  end

  // only the oldest match is removed
  assign hit = (state_q == pqr_pkg::S_ROTATE) && !found_q && key_hit;

  // ---- next state and cell control ----
  always_comb begin
    state_d    = state_q;
    occ_d      = occ_q;
    cnt_d      = cnt_q;
    found_d    = found_q;
    capt_d     = capt_q;
    ctrl       = '0;
    done       = 1'b0;
    done_res   = '0;

    unique case (state_q)
      pqr_pkg::S_IDLE: begin
        if (cmd_fire) begin
          unique case (cmd_op)
            pqr_pkg::OP_PUSH: begin
              done = 1'b1;
              if (occ_q == OCC_W'(QUEUE_DEPTH)) begin
                done_res.status = pqr_pkg::STAT_FULL;
              end else begin
                ctrl.push       = 1'b1;
                occ_d           = occ_q + OCC_W'(1);
                done_res.status = pqr_pkg::STAT_OK;
              end
            end
            pqr_pkg::OP_POP, pqr_pkg::OP_DEL_NAME, pqr_pkg::OP_DEL_PID: begin
              if (occ_q == '0) begin
                done            = 1'b1;
                done_res.status = pqr_pkg::STAT_EMPTY;
              end else begin
                state_d = pqr_pkg::S_ROTATE;
                found_d = 1'b0;
                // pop removes the head in one step, no rotation needed
                cnt_d   = (cmd_op == pqr_pkg::OP_POP) ? OCC_W'(1) : occ_q;
              end
            end
          endcase
        end
      end

      pqr_pkg::S_ROTATE: begin
        ctrl.shift = 1'b1;
        ctrl.wrap  = !hit;  // matched record leaves the row
        cnt_d      = cnt_q - OCC_W'(1);
        if (hit) begin
          found_d = 1'b1;
          capt_d  = head;
          occ_d   = occ_q - OCC_W'(1);
        end
        if (cnt_q == OCC_W'(1)) begin
          done = 1'b1;
          if (hit) begin
            done_res.status = pqr_pkg::STAT_OK;
            done_res.rec    = head;
          end else if (found_q) begin
            done_res.status = pqr_pkg::STAT_OK;
            done_res.rec    = capt_q;
          end else begin
            done_res.status = pqr_pkg::STAT_NOT_FOUND;
          end
        end
      end

      pqr_pkg::S_HOLD: begin
        if (out_free) begin
          state_d = pqr_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pqr_pkg::S_IDLE;
      end
    endcase

    // a finished result goes straight out or waits in the hold register
    if (done) begin
      state_d = out_free ? pqr_pkg::S_IDLE : pqr_pkg::S_HOLD;
    end
  end

  // ---- output register ----
  assign out_load = out_free && (done || (state_q == pqr_pkg::S_HOLD));
  assign out_d    = (state_q == pqr_pkg::S_HOLD) ? hold_q : done_res;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pqr_pkg::S_IDLE;
      occ_q       <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    capt_q <= capt_d;
    if (cmd_fire) begin
      op_q       <= cmd_op;
      key_name_q <= cmd_i.name_key;
      key_pid_q  <= cmd_i.pid_in;
    end
    if (done && !out_free) begin
      hold_q <= done_res;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_q.status;
  assign res_o.name_out    = out_q.rec.name;
  assign res_o.prio_out    = out_q.rec.prio;
  assign res_o.pid_out     = out_q.rec.pid;
  assign res_o.runtime_out = out_q.rec.runtime;

  // ---- assertions ----
  `PQR_ASSERT(a_occ_bound, clk_i, rst_ni, occ_q <= OCC_W'(QUEUE_DEPTH), "occupancy over depth")
  `PQR_ASSERT(a_rotate_cnt, clk_i, rst_ni, (state_q == pqr_pkg::S_ROTATE) |-> (cnt_q != '0), "rotate with no steps left")
  `PQR_ASSERT(a_hit_dec, clk_i, rst_ni, hit |=> (occ_q == $past(occ_q) - OCC_W'(1)), "removal did not shrink queue")
  `PQR_ASSERT(a_hold_valid, clk_i, rst_ni, (state_q == pqr_pkg::S_HOLD) |-> out_valid_q, "result held with free output")

endmodule

@@ rtl/pqr_cell.sv @@
// ----------------------------------------------------------------------------
// pqr_cell
// one queue slot: holds a record, takes its neighbor's record on a shift
// ----------------------------------------------------------------------------
module pqr_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned OCC_W = 5
) (
  input  logic                   clk_i,
  input  pqr_pkg::pqr_cell_ctrl_t ctrl_i,
  input  logic [OCC_W-1:0]       occ_i,
  input  pqr_pkg::pqr_rec_t      next_i,
  input  pqr_pkg::pqr_rec_t      head_i,
  input  pqr_pkg::pqr_rec_t      push_i,
  output pqr_pkg::pqr_rec_t      rec_o
);

  pqr_pkg::pqr_rec_t rec_q, rec_d;
  logic              is_tail;
  logic              is_fill;

  // last occupied slot, and first free slot
  assign is_tail = (occ_i == OCC_W'(IDX + 1));
  assign is_fill = (occ_i == OCC_W'(IDX));

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.shift) begin
      rec_d = (is_tail && ctrl_i.wrap) ? head_i : next_i;
    end else if (ctrl_i.push && is_fill) begin
      rec_d = push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

@@ dv/tb_process_queue_with_removal_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_process_queue_with_removal_unit
// self-checking bench for the process queue: commands go in on the command
// channel, a queue model in the bench predicts each status and removed record,
// and every result transaction is compared field by field, in order
// ----------------------------------------------------------------------------
module tb_process_queue_with_removal_unit;

  localparam int unsigned DEPTH        = 16;
  // overall cycle limit of the run, this leaves ample margin
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // once nothing is awaited, wait on for stray results
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;

  // one command as it travels on the command channel
  typedef struct packed {
    pqr_pkg::pqr_op_e  op;
    pqr_pkg::pqr_rec_t rec;
  } queue_cmd_t;

  logic clk = 1'b0;
  logic rst_n;

  pqr_cmd_if cmd_bus ();
  pqr_res_if res_bus ();

  process_queue_with_removal_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_bus),
    .res_o (res_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // bench copy of the queue contents, oldest record first
  pqr_pkg::pqr_rec_t    held_recs[$];
  // one predicted result per accepted command, oldest first
  pqr_pkg::pqr_result_t awaited_res[$];

  bit          idling_on;
  bit          filling_phase;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  // what the run went through, for the closing summary
  int unsigned n_push, n_full, n_pop, n_empty, n_del_hit, n_del_miss;

  // --------------------------------------------------------------------------
  // queue model: applies one command, returns the result it must produce
  // --------------------------------------------------------------------------
  function automatic pqr_pkg::pqr_result_t model_command(queue_cmd_t c);
    pqr_pkg::pqr_result_t r;
    int                   found;
    r        = '0;
    r.status = pqr_pkg::STAT_OK;
    found    = -1;
    if (c.op == pqr_pkg::OP_PUSH) begin
      // a refused push leaves the queue as it was
      if (held_recs.size() >= DEPTH) begin
        r.status = pqr_pkg::STAT_FULL;
        n_full++;
      end else begin
        held_recs.push_back(c.rec);
        n_push++;
      end
    end else if (held_recs.size() == 0) begin
      r.status = pqr_pkg::STAT_EMPTY;
      n_empty++;
    end else if (c.op == pqr_pkg::OP_POP) begin
      r.rec = held_recs.pop_front();
      n_pop++;
    end else begin
      // scan from the tail so the oldest match wins, head included
      for (int k = held_recs.size() - 1; k >= 0; k--) begin
        if ((c.op == pqr_pkg::OP_DEL_NAME) ? (held_recs[k].name == c.rec.name)
                                           : (held_recs[k].pid == c.rec.pid)) begin
          found = k;
        end
      end
      if (found < 0) begin
        r.status = pqr_pkg::STAT_NOT_FOUND;
        n_del_miss++;
      end else begin
        r.rec = held_recs[found];
        held_recs.delete(found);
        n_del_hit++;
      end
    end
    return r;
  endfunction

  function automatic queue_cmd_t make_cmd(pqr_pkg::pqr_op_e op, pqr_pkg::pqr_rec_t rec);
    queue_cmd_t c;
    c.op  = op;
    c.rec = rec;
    return c;
  endfunction

  // random record; the pool variant reuses a few names and pids so that
  // several held records share a key
  function automatic pqr_pkg::pqr_rec_t rand_rec(bit from_pool);
    pqr_pkg::pqr_rec_t r;
    r.name    = {$urandom, $urandom};
    r.prio    = 8'($urandom_range(0, 255));
    r.pid     = 22'($urandom_range(0, 22'h3FFFFF));
    r.runtime = 31'($urandom_range(0, 31'h7FFFFFFF));
    if (from_pool) begin
      case ($urandom_range(0, 3))
        0: r.name = {"init", 32'h0};
        1: r.name = {"sshd", 32'h0};
        2: r.name = {"kworker", 8'h0};
        default: r.name = "watchdog";
      endcase
      r.pid = 22'($urandom_range(1, 6));
    end
    return r;
  endfunction

  // next random command: phases of filling and draining sweep the occupancy
  // between empty and full, most deletes aim at a record that is held
  function automatic queue_cmd_t next_random_cmd();
    queue_cmd_t  c;
    int unsigned push_pct, rest, roll, idx;
    if (held_recs.size() == DEPTH) filling_phase = 1'b0;
    else if (held_recs.size() == 0) filling_phase = 1'b1;
    else if ($urandom_range(0, 29) == 0) filling_phase = !filling_phase;
    push_pct = filling_phase ? 65 : 25;
    rest     = 100 - push_pct;
    roll     = $urandom_range(0, 99);
    c.rec    = rand_rec($urandom_range(0, 2) == 0);
    if (roll < push_pct) c.op = pqr_pkg::OP_PUSH;
    else if (roll < push_pct + rest / 3) c.op = pqr_pkg::OP_POP;
    else if (roll < push_pct + 2 * rest / 3) c.op = pqr_pkg::OP_DEL_NAME;
    else c.op = pqr_pkg::OP_DEL_PID;
    if ((c.op == pqr_pkg::OP_DEL_NAME || c.op == pqr_pkg::OP_DEL_PID) &&
        held_recs.size() != 0 && $urandom_range(0, 3) != 0) begin
      idx        = $urandom_range(0, held_recs.size() - 1);
      c.rec.name = held_recs[idx].name;
      c.rec.pid  = held_recs[idx].pid;
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // command side: optional idle burst, then hold valid until accepted
  // --------------------------------------------------------------------------
  task automatic send_cmd(queue_cmd_t c);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.op         <= c.op;
    cmd_bus.name_key   <= c.rec.name;
    cmd_bus.prio_in    <= c.rec.prio;
    cmd_bus.pid_in     <= c.rec.pid;
    cmd_bus.runtime_in <= c.rec.runtime;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    awaited_res.push_back(model_command(c));
  endtask

  task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: check the transaction seen at this edge, then pick the
  // next ready value, stalling in bursts while idling is on
  // --------------------------------------------------------------------------
  initial begin
    int unsigned          stall_left;
    pqr_pkg::pqr_result_t want;
    stall_left    = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_bus.valid && res_bus.ready) begin
        if (awaited_res.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual status %0d",
                   $time, res_bus.status);
          mismatches++;
        end else begin
          want = awaited_res.pop_front();
          compare_field("status", 64'(want.status), 64'(res_bus.status));
          compare_field("name_out", want.rec.name, res_bus.name_out);
          compare_field("prio_out", 64'(want.rec.prio), 64'(res_bus.prio_out));
          compare_field("pid_out", 64'(want.rec.pid), 64'(res_bus.pid_out));
          compare_field("runtime_out", 64'(want.rec.runtime), 64'(res_bus.runtime_out));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        stall_left    = $urandom_range(0, 5);
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: cycle limit reached, %0d results still awaited",
               $time, awaited_res.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // pop and both deletes with nothing held
  task automatic test_empty_queue();
    send_cmd(make_cmd(pqr_pkg::OP_POP, rand_rec(1'b0)));
    send_cmd(make_cmd(pqr_pkg::OP_DEL_NAME, rand_rec(1'b0)));
    send_cmd(make_cmd(pqr_pkg::OP_DEL_PID, rand_rec(1'b0)));
  endtask

  // fill to the brim with an all-zero and an all-one record up front and two
  // later twins, then one push too many
  task automatic test_fill_and_extremes();
    pqr_pkg::pqr_rec_t r;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) r = '0;
      else if (i == 1) r = '1;
      else r = rand_rec(1'b0);
      if (i == 5) r.name = held_recs[2].name;
      if (i == 7) r.pid = held_recs[3].pid;
      send_cmd(make_cmd(pqr_pkg::OP_PUSH, r));
    end
    send_cmd(make_cmd(pqr_pkg::OP_PUSH, rand_rec(1'b0)));
  endtask

  // oldest of two matches, absent keys, tail and head removal, final pop
  task automatic test_delete_cases();
    pqr_pkg::pqr_rec_t twin_name_rec, twin_pid_rec, r;
    twin_name_rec = held_recs[2];
    twin_pid_rec  = held_recs[3];
    send_cmd(make_cmd(pqr_pkg::OP_DEL_NAME, twin_name_rec));
    send_cmd(make_cmd(pqr_pkg::OP_DEL_NAME, twin_name_rec));
    send_cmd(make_cmd(pqr_pkg::OP_DEL_PID, twin_pid_rec));
    r      = rand_rec(1'b0);
    r.name = {"nosuch", 16'h0};
    r.pid  = 22'h3FFFFE;
    send_cmd(make_cmd(pqr_pkg::OP_DEL_NAME, r));
    send_cmd(make_cmd(pqr_pkg::OP_DEL_PID, r));
    send_cmd(make_cmd(pqr_pkg::OP_DEL_PID, held_recs[held_recs.size() - 1]));
    send_cmd(make_cmd(pqr_pkg::OP_DEL_NAME, held_recs[0]));
    send_cmd(make_cmd(pqr_pkg::OP_POP, rand_rec(1'b0)));
  endtask

  // random traffic with idle bursts, and a quiet stretch every 200 commands
  task automatic test_random_mix(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      idling_on = (n % 200) < 150;
      send_cmd(next_random_cmd());
    end
  endtask

  // back-to-back commands and an always-ready receiver
  task automatic test_full_rate(int unsigned count);
    idling_on = 1'b0;
    for (int unsigned n = 0; n < count; n++) begin
      send_cmd(next_random_cmd());
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    idling_on          = 1'b1;
    filling_phase      = 1'b1;
    cmd_bus.valid      <= 1'b0;
    cmd_bus.op         <= pqr_pkg::OP_PUSH;
    cmd_bus.name_key   <= '0;
    cmd_bus.prio_in    <= '0;
    cmd_bus.pid_in     <= '0;
    cmd_bus.runtime_in <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_fill_and_extremes();
    test_delete_cases();
    test_random_mix(1200);
    test_full_rate(200);

    cmd_bus.valid <= 1'b0;
    while (awaited_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d pushes, %0d refused on a full queue, %0d pops",
             n_push, n_full, n_pop);
    $display("plus %0d deletes that hit, %0d that missed, %0d commands on an empty queue",
             n_del_hit, n_del_miss, n_empty);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
